@@ rtl/core/g2bp_pkg.sv @@
`default_nettype none

package g2bp_pkg;

   // pixel_depth_mode codes
   localparam logic [1:0] DEPTH_2BPP = 2'd0;
   localparam logic [1:0] DEPTH_4BPP = 2'd1;
   localparam logic [1:0] DEPTH_8BPP = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_DEPTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT      = 2'd1;
   localparam int unsigned CSR_DATA_W = 8;

   // pixel masks and grey1 thresholds, pixel left aligned in a byte
   localparam logic [7:0] MASK_2BPP  = 8'hC0;
   localparam logic [7:0] MASK_4BPP  = 8'hF0;
   localparam logic [7:0] MASK_8BPP  = 8'hFF;
   localparam logic [7:0] GREY1_2BPP = 8'h80;
   localparam logic [7:0] GREY1_4BPP = 8'hA0;
   localparam logic [7:0] GREY1_8BPP = 8'hA0;

   // last byte index of a group (bpp - 1)
   localparam logic [2:0] LAST_2BPP = 3'd1;
   localparam logic [2:0] LAST_4BPP = 3'd3;
   localparam logic [2:0] LAST_8BPP = 3'd7;

   typedef struct packed {
      logic [7:0] prev;
      logic [7:0] cur;
      logic [2:0] count;
   } acc_type;

   typedef struct packed {
      acc_type    acc_next;   // state after this byte, cleared on emit
      logic       emit;       // group complete, result bytes valid
      logic [7:0] prev_byte;
      logic [7:0] cur_byte;
   } step_type;

   // {prev bit, cur bit} for one left-aligned, masked pixel
   function automatic logic [1:0] classify(input logic [7:0] pix,
                                           input logic [7:0] mask,
                                           input logic [7:0] grey1);
      logic [1:0] bits;
      if (pix == mask) begin
         bits = 2'b11;          // white
      end else if (pix == 8'h00) begin
         bits = 2'b00;          // black
      end else if (pix >= grey1) begin
         bits = 2'b10;          // grey1
      end else begin
         bits = 2'b01;          // grey2
      end
      return bits;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/g2bp_classify.sv @@
`default_nettype none

// One byte's worth of pixel classification and plane shifting.
module g2bp_classify (
   input  wire logic [7:0]       pixel_byte,
   input  wire logic [1:0]       depth_mode,
   input  wire logic             invert,
   input  wire g2bp_pkg::acc_type acc,
   output g2bp_pkg::step_type    step
);
   import g2bp_pkg::*;

   logic [7:0] b;
   logic [3:0] pb2, cb2;
   logic [1:0] pb4, cb4;
   logic [1:0] bits8;
   logic [1:0] bits_t;
   logic [7:0] prev_new, cur_new;
   logic [2:0] last;
   logic       active;

   assign b = invert ? ~pixel_byte : pixel_byte;

   always_comb begin
      // 2 bpp: four pixels, leftmost pixel lands in the higher bit
      for (int n = 0; n < 4; n++) begin
         bits_t = classify({b[7-2*n -: 2], 6'b0}, MASK_2BPP, GREY1_2BPP);
         pb2[3-n] = bits_t[1];
         cb2[3-n] = bits_t[0];
      end
      for (int n = 0; n < 2; n++) begin
         bits_t = classify({b[7-4*n -: 4], 4'b0}, MASK_4BPP, GREY1_4BPP);
         pb4[1-n] = bits_t[1];
         cb4[1-n] = bits_t[0];
      end
      bits8 = classify(b, MASK_8BPP, GREY1_8BPP);
   end

   always_comb begin
      active   = 1'b1;
      prev_new = acc.prev;
      cur_new  = acc.cur;
      last     = LAST_8BPP;
      unique case (depth_mode)
         DEPTH_2BPP: begin
            prev_new = {acc.prev[3:0], pb2};
            cur_new  = {acc.cur[3:0], cb2};
            last     = LAST_2BPP;
         end
         DEPTH_4BPP: begin
            prev_new = {acc.prev[5:0], pb4};
            cur_new  = {acc.cur[5:0], cb4};
            last     = LAST_4BPP;
         end
         DEPTH_8BPP: begin
            prev_new = {acc.prev[6:0], bits8[1]};
            cur_new  = {acc.cur[6:0], bits8[0]};
            last     = LAST_8BPP;
         end
         default: begin
            active = 1'b0;      // unused code: byte dropped, state kept
         end
      endcase
   end

   always_comb begin
      step.emit      = active && (acc.count >= last);
      step.prev_byte = prev_new;
      step.cur_byte  = cur_new;
      if (!active) begin
         step.acc_next = acc;
      end else if (step.emit) begin
         step.acc_next = '0;
      end else begin
         step.acc_next.prev  = prev_new;
         step.acc_next.cur   = cur_new;
         step.acc_next.count = acc.count + 3'd1;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/grey_to_dual_bitplane_packer.sv @@
`default_nettype none

// Channel  | Direction | Payload
// ---------+-----------+--------------------------------------------------
// req_     | in        | tdata[7:0] pixel_byte
// rsp_     | out       | tdata[7:0] previous_plane_byte, [15:8] current_plane_byte
// csr_     | in        | index 0 pixel_depth_mode, 1 invert_pixels
//
// One byte per cycle sustained unless a group-completing byte meets a stalled output.
// A byte is registered on transfer, classified and shifted into the plane accumulators
// as it leaves the input stage, and a finished pair of plane bytes sits in the output
// register. Synchronous active-high reset clears accumulators, group count, configuration
// and valid flags. A stalled output only holds the input stage when its byte completes a group.
module grey_to_dual_bitplane_packer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,   // [7:0] pixel_byte
   // result stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [15:0]                             rsp_tdata,   // [7:0] previous_plane_byte,
                                                                // [15:8] current_plane_byte
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [g2bp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [g2bp_pkg::CSR_DATA_W-1:0]    csr_data
);
   import g2bp_pkg::*;

   // configuration
   logic [1:0] depth_ff, depth_in;
   logic       invert_ff, invert_in;

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;

   // plane accumulators and group count
   acc_type    acc_ff, acc_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   step_type step;
   logic     rsp_free;
   logic     s1_advance;

   g2bp_classify u_classify (
      .pixel_byte (s1_byte_ff),
      .depth_mode (depth_ff),
      .invert     (invert_ff),
      .acc        (acc_ff),
      .step       (step)
   );

   assign csr_ready = 1'b1;

   // output slot opens when empty or when its pair is taken this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // only a group-completing byte needs the output slot
   assign s1_advance = s1_valid_ff && (!step.emit || rsp_free);
   assign req_tready = !s1_valid_ff || s1_advance;

   always_comb begin
      depth_in  = depth_ff;
      invert_in = invert_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PIXEL_DEPTH) begin
            depth_in = csr_data[1:0];
         end else if (csr_index == CSR_INVERT) begin
            invert_in = csr_data[0];
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   assign acc_in = s1_advance ? step.acc_next : acc_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_free) begin
         rsp_valid_in = s1_advance && step.emit;
         if (s1_advance && step.emit) begin
            rsp_data_in = {step.cur_byte, step.prev_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= DEPTH_2BPP;
         invert_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         invert_ff    <= invert_in;
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a held input byte stays held
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff)
      else $error("input stage byte lost while stalled");

   // a new result only comes from a byte that just left the input stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_advance && step.emit))
      else $error("result appeared without a completed group");

   // a completed group leaves empty accumulators behind
   assert property (@(posedge clock) disable iff (reset)
      s1_advance && step.emit |=> acc_ff == '0)
      else $error("accumulators not cleared after emit");

endmodule

`default_nettype wire
